// ===== rtl/fwkrl_pkg.sv =====
// Shared types, widths and codes of the fixed window key rate limiter.
package fwkrl_pkg;

  localparam int KEY_W        = 32;
  localparam int TIME_W       = 32;
  localparam int LIMIT_W      = 16;
  localparam int WINDOW_W     = 17;
  localparam int COUNT_W      = 16;
  localparam int OUTCOME_W    = 3;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 17;

  localparam int DEFAULT_TABLE_ENTRIES = 64;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(100);
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_REQUEST_LIMIT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_NEW       = 3'd0,
    OUT_RESTART   = 3'd1,
    OUT_COUNTED   = 3'd2,
    OUT_DENIED    = 3'd3,
    OUT_UNTRACKED = 3'd4
  } outcome_t;

  // A request as it travels down the row of table cells.
  typedef struct packed {
    logic               valid;
    logic               resolved;
    logic [KEY_W-1:0]   client_key;
    logic [TIME_W-1:0]  now_seconds;
    logic               allowed;
    outcome_t           outcome;
    logic [COUNT_W-1:0] window_count;
  } token_t;

endpackage

// ===== rtl/fwkrl_req_if.sv =====
// Request channel: client key and current time.
interface fwkrl_req_if import fwkrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  client_key;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, output client_key, output now_seconds, input ready);
  modport sink   (input valid, input client_key, input now_seconds, output ready);
endinterface

// ===== rtl/fwkrl_res_if.sv =====
// Result channel: decision, outcome code and window count.
interface fwkrl_res_if import fwkrl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 allowed;
  logic [OUTCOME_W-1:0] outcome;
  logic [COUNT_W-1:0]   window_count;

  modport source (output valid, output allowed, output outcome, output window_count,
                  input ready);
  modport sink   (input valid, input allowed, input outcome, input window_count,
                  output ready);
endinterface

// ===== rtl/fwkrl_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface fwkrl_cfg_if import fwkrl_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fixed_window_key_rate_limiter_core.sv =====
// Top level of the fixed window key rate limiter: a row of table cells and a result register.
//
// Usage: each request transfer on req carries a client key and the current
// time in seconds; each one yields exactly one result transfer on res, in
// order, with the decision, an outcome code and the entry's count.
// The key table is a row of TABLE_ENTRIES identical cells, one entry each.
// A request moves one cell per cycle; the cell that holds its key, or the
// first free cell, resolves it as it goes by and updates its entry unless
// it denies it. Requests follow each other at least one cell apart, so every
// request sees the table exactly as the requests before it left it.
// Throughput is one request per cycle while res does not stall; the cell row
// sets the latency, and the per-cell key compare plus the window subtract and
// compare set the clock. When res stalls, the whole row holds and req.ready
// drops; a finished result waits in the result register. The user must make
// cfg writes only while no request is in flight; the block does not enforce
// this. Reset clears every entry's valid mark, drops requests in flight and
// restores request_limit to 100 and window_length to 60.
module fixed_window_key_rate_limiter_core import fwkrl_pkg::*; #(
  parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  fwkrl_cfg_if.sink   cfg,
  fwkrl_req_if.sink   req,
  fwkrl_res_if.source res
);

  logic [LIMIT_W-1:0]  request_limit;
  logic [WINDOW_W-1:0] window_length;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      request_limit <= LIMIT_RESET;
      window_length <= WINDOW_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_REQUEST_LIMIT: request_limit <= cfg.data[LIMIT_W-1:0];
        REG_WINDOW_LENGTH: window_length <= cfg.data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // The row advances whenever the result register is free or being emptied.
  logic advance;
  logic res_valid;

  assign advance   = !res_valid || res.ready;
  assign req.ready = advance;

  token_t                   tok [0:TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_vec;

  always_comb begin
    tok[0]              = '0;
    tok[0].valid        = req.valid;
    tok[0].resolved     = 1'b0;
    tok[0].client_key   = req.client_key;
    tok[0].now_seconds  = req.now_seconds;
    tok[0].allowed      = 1'b1;
    tok[0].outcome      = OUT_UNTRACKED;
    tok[0].window_count = '0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    fwkrl_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .advance       (advance),
      .request_limit (request_limit),
      .window_length (window_length),
      .tok_in        (tok[i]),
      .tok_out       (tok[i+1]),
      .entry_used    (valid_vec[i])
    );
  end

  // Result register. A request that leaves the row unresolved found neither
  // its key nor a free entry, and is let through untracked.
  logic                 res_allowed;
  logic [OUTCOME_W-1:0] res_outcome;
  logic [COUNT_W-1:0]   res_window_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= tok[TABLE_ENTRIES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (tok[TABLE_ENTRIES].resolved) begin
        res_allowed      <= tok[TABLE_ENTRIES].allowed;
        res_outcome      <= tok[TABLE_ENTRIES].outcome;
        res_window_count <= tok[TABLE_ENTRIES].window_count;
      end else begin
        res_allowed      <= 1'b1;
        res_outcome      <= OUT_UNTRACKED;
        res_window_count <= '0;
      end
    end
  end

  assign res.valid        = res_valid;
  assign res.allowed      = res_allowed;
  assign res.outcome      = res_outcome;
  assign res.window_count = res_window_count;

  // Entries are only ever claimed lowest free first, so the used entries
  // always form an unbroken run from entry zero.
  a_used_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("used table entries are not contiguous from entry zero");

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

  // A new entry or a restarted window always allows with a count of one.
  a_fresh_count: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.outcome == OUT_NEW || res.outcome == OUT_RESTART)
      |-> res.allowed && res.window_count == COUNT_W'(1))
    else $error("new or restarted window without allow and count of one");

  // A denial only happens once the count has reached the limit.
  a_denied_limit: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.outcome == OUT_DENIED
      |-> !res.allowed && res.window_count >= request_limit)
    else $error("denied result below the request limit");

endmodule

// ===== rtl/fwkrl_cell.sv =====
// One table entry of the limiter, acting on the request that passes through it.
module fwkrl_cell import fwkrl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [LIMIT_W-1:0]  request_limit,
  input  logic [WINDOW_W-1:0] window_length,
  input  token_t              tok_in,
  output token_t              tok_out,
  output logic                entry_used
);

  logic               entry_valid;
  logic [KEY_W-1:0]   entry_key;
  logic [TIME_W-1:0]  entry_window_start;
  logic [COUNT_W-1:0] entry_count;

  logic               tok_valid;
  token_t             tok_q;
  token_t             tok_next;

  logic               claim;
  logic               entry_write;
  logic [TIME_W-1:0]  entry_window_start_next;
  logic [COUNT_W-1:0] entry_count_next;
  logic [TIME_W-1:0]  elapsed;

  always_comb begin
    tok_next                = tok_in;
    claim                   = 1'b0;
    entry_write             = 1'b0;
    entry_window_start_next = entry_window_start;
    entry_count_next        = entry_count;
    elapsed                 = tok_in.now_seconds - entry_window_start;
    if (tok_in.valid && !tok_in.resolved) begin
      if (!entry_valid) begin
        // Entries fill from the lowest index up, so the first free cell
        // also means no later cell can hold this key.
        claim                   = 1'b1;
        entry_write             = 1'b1;
        entry_window_start_next = tok_in.now_seconds;
        entry_count_next        = COUNT_W'(1);
        tok_next.resolved       = 1'b1;
        tok_next.allowed        = 1'b1;
        tok_next.outcome        = OUT_NEW;
        tok_next.window_count   = COUNT_W'(1);
      end else if (entry_key == tok_in.client_key) begin
        tok_next.resolved = 1'b1;
        if (elapsed >= TIME_W'(window_length)) begin
          entry_write             = 1'b1;
          entry_window_start_next = tok_in.now_seconds;
          entry_count_next        = COUNT_W'(1);
          tok_next.allowed        = 1'b1;
          tok_next.outcome        = OUT_RESTART;
          tok_next.window_count   = COUNT_W'(1);
        end else if (entry_count >= request_limit) begin
          tok_next.allowed      = 1'b0;
          tok_next.outcome      = OUT_DENIED;
          tok_next.window_count = entry_count;
        end else begin
          entry_write           = 1'b1;
          entry_count_next      = entry_count + COUNT_W'(1);
          tok_next.allowed      = 1'b1;
          tok_next.outcome      = OUT_COUNTED;
          tok_next.window_count = entry_count + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      tok_valid   <= 1'b0;
    end else if (advance) begin
      tok_valid <= tok_in.valid;
      if (claim) begin
        entry_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok_q <= tok_next;
      if (entry_write) begin
        entry_window_start <= entry_window_start_next;
        entry_count        <= entry_count_next;
      end
      if (claim) begin
        entry_key <= tok_in.client_key;
      end
    end
  end

  always_comb begin
    tok_out       = tok_q;
    tok_out.valid = tok_valid;
  end

  assign entry_used = entry_valid;

endmodule
